>>> hw/rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debounce / long press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   localparam int unsigned NUM_BTN = 3;

   // button positions, also the order in which events leave
   localparam int unsigned BTN_UP   = 0;
   localparam int unsigned BTN_DOWN = 1;
   localparam int unsigned BTN_OK   = 2;

   // event codes
   localparam logic [1:0] EV_UP_SHORT   = 2'd0;
   localparam logic [1:0] EV_DOWN_SHORT = 2'd1;
   localparam logic [1:0] EV_OK_SHORT   = 2'd2;
   localparam logic [1:0] EV_OK_LONG    = 2'd3;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_POLARITY   = 2'd2;

   localparam logic [3:0]  DEBOUNCE_RESET   = 4'd2;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd800;
   localparam logic [2:0]  POLARITY_RESET   = 3'b111;

   // what one lane reports for the current poll
   typedef struct packed {
      logic fire;
      logic long_press;
   } lane_event_type;

endpackage

>>> hw/rtl/bdlp_lane.sv
// ----------------------------------------------------------------------------
// bdlp_lane
// Debounce and press timing for one button; reports at most one event a poll.
// ----------------------------------------------------------------------------
module bdlp_lane #(
   parameter int unsigned TIME_WIDTH = 32,
   parameter bit          HAS_LONG   = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    seed,
   input  logic                    cur_pressed,
   input  logic [3:0]              debounce_samples,
   input  logic [15:0]             long_press_ms,
   input  logic [TIME_WIDTH-1:0]   now,
   output bdlp_pkg::lane_event_type ev
);

   logic       raw_ff, raw_in;
   logic       stable_ff, stable_in;
   logic [3:0] count_ff, count_in;

   logic       raw_base, stable_base;
   logic [3:0] count_base;
   logic       flip, press, release_hit;

   always_comb begin
      // the first poll seeds the button with its current state
      raw_base    = seed ? cur_pressed : raw_ff;
      stable_base = seed ? cur_pressed : stable_ff;
      count_base  = seed ? debounce_samples : count_ff;

      if (cur_pressed == raw_base) begin
         raw_in   = raw_base;
         count_in = (count_base < debounce_samples) ? count_base + 4'd1 : count_base;
      end else begin
         raw_in   = cur_pressed;
         count_in = 4'd0;
      end

      flip        = (count_in >= debounce_samples) && (stable_base != raw_in);
      stable_in   = flip ? raw_in : stable_base;
      press       = flip && raw_in;
      release_hit = flip && !raw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         stable_ff <= 1'b0;
         count_ff  <= 4'd0;
      end else if (step) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

   generate
      if (HAS_LONG) begin : g_long
         logic [TIME_WIDTH-1:0] start_ff, start_in;
         logic                  long_done_ff, long_done_in;
         logic [TIME_WIDTH-1:0] held;
         logic                  long_hit;

         always_comb begin
            held         = now - start_ff;
            long_hit     = held >= TIME_WIDTH'(long_press_ms);
            start_in     = start_ff;
            long_done_in = long_done_ff;
            ev.fire       = 1'b0;
            ev.long_press = 1'b0;
            if (press) begin
               start_in     = now;
               long_done_in = 1'b0;
            end else if (release_hit) begin
               ev.fire       = step && !long_done_ff;
               ev.long_press = long_hit;
            end else if (stable_base && !long_done_ff && long_hit) begin
               // report long once while still held
               long_done_in  = 1'b1;
               ev.fire       = step;
               ev.long_press = 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               start_ff     <= '0;
               long_done_ff <= 1'b0;
            end else if (step) begin
               start_ff     <= start_in;
               long_done_ff <= long_done_in;
            end
         end
      end else begin : g_short
         always_comb begin
            ev.fire       = step && release_hit;
            ev.long_press = 1'b0;
         end
      end
   endgenerate

endmodule

>>> hw/rtl/bdlp_merge.sv
// ----------------------------------------------------------------------------
// bdlp_merge
// Collects the lane events of one poll and sends them out in button order.
// ----------------------------------------------------------------------------
module bdlp_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  bdlp_pkg::lane_event_type lane_ev [bdlp_pkg::NUM_BTN],
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_event_code,
   output logic                     rsp_is_last
);

   logic [bdlp_pkg::NUM_BTN-1:0] pend_ff, pend_in;
   logic [bdlp_pkg::NUM_BTN-1:0] long_ff, long_in;
   logic [bdlp_pkg::NUM_BTN-1:0] taken, fresh, fresh_long;
   logic                         xfer;

   always_comb begin
      for (int b = 0; b < bdlp_pkg::NUM_BTN; b++) begin
         fresh[b]      = lane_ev[b].fire;
         fresh_long[b] = lane_ev[b].long_press;
      end

      rsp_valid = |pend_ff;
      xfer      = rsp_valid && rsp_ready;
      taken     = '0;
      if (pend_ff[bdlp_pkg::BTN_UP]) begin
         taken[bdlp_pkg::BTN_UP] = 1'b1;
         rsp_event_code = bdlp_pkg::EV_UP_SHORT;
         rsp_is_last    = !pend_ff[bdlp_pkg::BTN_DOWN] && !pend_ff[bdlp_pkg::BTN_OK];
      end else if (pend_ff[bdlp_pkg::BTN_DOWN]) begin
         taken[bdlp_pkg::BTN_DOWN] = 1'b1;
         rsp_event_code = bdlp_pkg::EV_DOWN_SHORT;
         rsp_is_last    = !pend_ff[bdlp_pkg::BTN_OK];
      end else begin
         taken[bdlp_pkg::BTN_OK] = 1'b1;
         rsp_event_code = long_ff[bdlp_pkg::BTN_OK] ? bdlp_pkg::EV_OK_LONG
                                                    : bdlp_pkg::EV_OK_SHORT;
         rsp_is_last    = 1'b1;
      end

      // take a new poll when empty or when the last pending event leaves now
      can_load = !rsp_valid || (xfer && rsp_is_last);

      pend_in = xfer ? (pend_ff & ~taken) : pend_ff;
      long_in = long_ff;
      if (load) begin
         pend_in = fresh;
         long_in = fresh_long;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      long_ff <= long_in;
   end

endmodule

>>> hw/rtl/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Three-button debounce with short and long press events, one lane a button.
// ----------------------------------------------------------------------------
//  channel  direction  transfer when            payload
//  req      in         req_valid & req_ready    up/down/ok level, now_ms
//  rsp      out        rsp_valid & rsp_ready    event_code, is_last
//  csr      in/out     psel&penable&pwrite      debounce, long press, polarity
//
//  A poll is taken when req_valid & req_ready; the three lanes update and their
//  events are registered in the merge stage, which sends one event a cycle while rsp_ready is high.
//  A poll with n events gives n transfers, so at most 3 transfers a poll.
//  req_ready is high when no event is pending or the last one leaves now.
//  rsp stalls hold the pending events; reset is synchronous, no clearing pass.
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_up_level,
   input  logic        req_down_level,
   input  logic        req_ok_level,
   input  logic [31:0] req_now_ms,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_code,
   output logic        rsp_is_last,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0]  debounce_ff, debounce_in;
   logic [15:0] long_press_ff, long_press_in;
   logic [2:0]  polarity_ff, polarity_in;
   logic        seeded_ff, seeded_in;

   logic                          csr_write;
   logic                          step;
   logic                          can_load;
   logic [bdlp_pkg::NUM_BTN-1:0]  level, pressed;
   logic [TIME_WIDTH-1:0]         now;
   bdlp_pkg::lane_event_type      lane_ev [bdlp_pkg::NUM_BTN];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      polarity_in   = polarity_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            bdlp_pkg::REG_DEBOUNCE:   debounce_in   = csr_pwdata[3:0];
            bdlp_pkg::REG_LONG_PRESS: long_press_in = csr_pwdata[15:0];
            bdlp_pkg::REG_POLARITY:   polarity_in   = csr_pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         bdlp_pkg::REG_DEBOUNCE:   csr_prdata = {28'd0, debounce_ff};
         bdlp_pkg::REG_LONG_PRESS: csr_prdata = {16'd0, long_press_ff};
         bdlp_pkg::REG_POLARITY:   csr_prdata = {29'd0, polarity_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // poll intake
   assign req_ready = can_load;
   assign step      = req_valid && req_ready;
   assign seeded_in = seeded_ff || step;
   assign now       = TIME_WIDTH'(req_now_ms);

   assign level[bdlp_pkg::BTN_UP]   = req_up_level;
   assign level[bdlp_pkg::BTN_DOWN] = req_down_level;
   assign level[bdlp_pkg::BTN_OK]   = req_ok_level;
   assign pressed = level ^ polarity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bdlp_pkg::DEBOUNCE_RESET;
         long_press_ff <= bdlp_pkg::LONG_PRESS_RESET;
         polarity_ff   <= bdlp_pkg::POLARITY_RESET;
         seeded_ff     <= 1'b0;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
         polarity_ff   <= polarity_in;
         seeded_ff     <= seeded_in;
      end
   end

   generate
      for (genvar b = 0; b < bdlp_pkg::NUM_BTN; b++) begin : g_lane
         bdlp_lane #(
            .TIME_WIDTH (TIME_WIDTH),
            .HAS_LONG   (b == bdlp_pkg::BTN_OK)
         ) u_lane (
            .clock            (clock),
            .reset            (reset),
            .step             (step),
            .seed             (!seeded_ff),
            .cur_pressed      (pressed[b]),
            .debounce_samples (debounce_ff),
            .long_press_ms    (long_press_ff),
            .now              (now),
            .ev               (lane_ev[b])
         );
      end
   endgenerate

   bdlp_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (step),
      .lane_ev        (lane_ev),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

>>> hw/rtl/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of event ordering and intake for the debounce block.
// ----------------------------------------------------------------------------
module bdlp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_code,
   input logic       rsp_is_last
);

   // a stalled event holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
                                  && $stable(rsp_is_last))
      else $error("stalled event changed");

   // ok events come from the last lane, so they always close a poll
   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == bdlp_pkg::EV_OK_SHORT ||
                    rsp_event_code == bdlp_pkg::EV_OK_LONG) |-> rsp_is_last)
      else $error("ok event not last of its poll");

   // events of one poll leave in rising button order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last |=>
         rsp_valid && (rsp_event_code > $past(rsp_event_code)))
      else $error("events of a poll out of order or missing");

   // no new poll while more than one event is pending
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> !req_ready)
      else $error("poll taken in the middle of a batch");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code),
   .rsp_is_last    (rsp_is_last)
);

>>> verif/button_debounce_long_press_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// Drives polls of three raw button levels and a timestamp into the block,
// predicts the short and long press events of each poll, and checks every
// event transfer in order. Register writes fall between phases while idle.
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [1:0] code;
      logic       last;
   } btn_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_up_level = 1'b1;
   logic        req_down_level = 1'b1;
   logic        req_ok_level = 1'b1;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_code;
   logic        rsp_is_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of configuration and per-button state
   logic [3:0]  cfg_debounce = bdlp_pkg::DEBOUNCE_RESET;
   logic [15:0] cfg_long_ms = bdlp_pkg::LONG_PRESS_RESET;
   logic [2:0]  cfg_active_low = bdlp_pkg::POLARITY_RESET;
   logic        seen_first = 1'b0;
   logic [2:0]  raw_press = '0;
   logic [2:0]  stable_press = '0;
   logic [3:0]  eq_count [3] = '{default: '0};
   logic [31:0] press_start [3] = '{default: '0};
   logic [2:0]  long_sent = '0;

   btn_event_type expected_events [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [2:0]  held_levels = 3'b111;
   logic [31:0] poll_time = '0;

   button_debounce_long_press u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_up_level   (req_up_level),
      .req_down_level (req_down_level),
      .req_ok_level   (req_ok_level),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .rsp_is_last    (rsp_is_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // lvl: bit0 up, bit1 down, bit2 ok
   function automatic void predict_button_events(input logic [2:0] lvl,
                                                 input logic [31:0] now);
      logic [2:0]  cur;
      logic [1:0]  evs [3];
      logic [31:0] held;
      int          n;
      int          b;
      cur = lvl ^ cfg_active_low;
      n = 0;
      if (!seen_first) begin
         raw_press = cur;
         stable_press = cur;
         for (b = 0; b < bdlp_pkg::NUM_BTN; b++) eq_count[b] = cfg_debounce;
         seen_first = 1'b1;
      end
      for (b = 0; b < bdlp_pkg::NUM_BTN; b++) begin
         if (cur[b] == raw_press[b]) begin
            if (eq_count[b] < cfg_debounce) eq_count[b] = eq_count[b] + 4'd1;
         end else begin
            raw_press[b] = cur[b];
            eq_count[b] = '0;
         end
         held = now - press_start[b];
         if (eq_count[b] >= cfg_debounce && stable_press[b] != raw_press[b]) begin
            stable_press[b] = raw_press[b];
            if (stable_press[b]) begin
               press_start[b] = now;
               long_sent[b] = 1'b0;
            end else if (b != bdlp_pkg::BTN_OK) begin
               evs[n] = (b == bdlp_pkg::BTN_UP) ? bdlp_pkg::EV_UP_SHORT
                                                : bdlp_pkg::EV_DOWN_SHORT;
               n++;
            end else if (!long_sent[b]) begin
               evs[n] = (held >= {16'd0, cfg_long_ms}) ? bdlp_pkg::EV_OK_LONG
                                                       : bdlp_pkg::EV_OK_SHORT;
               n++;
            end
         end else if (b == bdlp_pkg::BTN_OK && stable_press[b] && !long_sent[b]) begin
            if (held >= {16'd0, cfg_long_ms}) begin
               long_sent[b] = 1'b1;
               evs[n] = bdlp_pkg::EV_OK_LONG;
               n++;
            end
         end
      end
      for (b = 0; b < n; b++)
         expected_events.push_back(btn_event_type'{evs[b], (b == n - 1)});
   endfunction

   // receiver stalls and the event check share one clocked process
   always @(posedge clock) begin : check_events
      btn_event_type want;
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event transfer, code %0d is_last %0d",
                     $time, rsp_event_code, rsp_is_last);
            fail_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_code !== want.code) begin
               $display("%0t: event_code expected %0d actual %0d",
                        $time, want.code, rsp_event_code);
               fail_count++;
            end
            if (rsp_is_last !== want.last) begin
               $display("%0t: is_last expected %0d actual %0d",
                        $time, want.last, rsp_is_last);
               fail_count++;
            end
         end
      end
   end

   // write one register, then read it back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] keep;
      case (idx)
         bdlp_pkg::REG_DEBOUNCE: begin
            cfg_debounce = val[3:0];
            keep = {28'd0, val[3:0]};
         end
         bdlp_pkg::REG_LONG_PRESS: begin
            cfg_long_ms = val[15:0];
            keep = {16'd0, val[15:0]};
         end
         default: begin
            cfg_active_low = val[2:0];
            keep = {29'd0, val[2:0]};
         end
      endcase
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== keep) begin
         $display("%0t: register %0d read expected %0h actual %0h",
                  $time, idx, keep, csr_prdata);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_poll(input logic [2:0] lvl, input logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_up_level <= lvl[0];
      req_down_level <= lvl[1];
      req_ok_level <= lvl[2];
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      predict_button_events(lvl, now);
   endtask

   // wait for every event, then let a poll with no event finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // first poll seeds with ok held; press start is zero so ok reports long
   task automatic test_first_poll();
      send_poll(3'b001, 32'd900);
      send_poll(3'b111, 32'd1000);
      send_poll(3'b111, 32'd1025);
      send_poll(3'b111, 32'd1050);
      wait_idle();
   endtask

   task automatic test_zero_samples();
      csr_write(bdlp_pkg::REG_DEBOUNCE, 32'd0);
      send_poll(3'b000, 32'd2000);
      send_poll(3'b111, 32'd2010);
      wait_idle();
      csr_write(bdlp_pkg::REG_LONG_PRESS, 32'd0);
      send_poll(3'b011, 32'd2020);
      send_poll(3'b011, 32'd2020);
      send_poll(3'b111, 32'd2030);
      wait_idle();
   endtask

   task automatic test_time_wrap();
      csr_write(bdlp_pkg::REG_LONG_PRESS, 32'h0000_FFFF);
      send_poll(3'b011, 32'hFFFF_FFF0);
      send_poll(3'b011, 32'h0000_FFEE);
      send_poll(3'b011, 32'h0000_FFEF);
      send_poll(3'b111, 32'h0001_0000);
      send_poll(3'b011, 32'hFFFF_FFFF);
      send_poll(3'b111, 32'h0000_0005);
      wait_idle();
   endtask

   // new polarity applies from the next poll on
   task automatic test_polarity();
      csr_write(bdlp_pkg::REG_POLARITY, 32'd0);
      csr_write(bdlp_pkg::REG_DEBOUNCE, 32'd1);
      send_poll(3'b111, 32'd100);
      send_poll(3'b111, 32'd110);
      send_poll(3'b000, 32'd120);
      send_poll(3'b000, 32'd130);
      wait_idle();
   endtask

   // lowering the threshold below a count keeps the count
   task automatic test_count_above_threshold();
      csr_write(bdlp_pkg::REG_DEBOUNCE, 32'd3);
      send_poll(3'b000, 32'd140);
      send_poll(3'b000, 32'd150);
      wait_idle();
      csr_write(bdlp_pkg::REG_DEBOUNCE, 32'd1);
      send_poll(3'b000, 32'd160);
      send_poll(3'b001, 32'd170);
      send_poll(3'b001, 32'd180);
      send_poll(3'b000, 32'd190);
      send_poll(3'b000, 32'd200);
      wait_idle();
   endtask

   // held levels flip about once per debounce window, with short glitches
   task automatic test_random_polls(input int n, input int idle_pct, input int stall_pct,
                                    input logic [3:0] deb, input logic [15:0] long_ms,
                                    input logic [2:0] pol);
      logic [2:0] lvl;
      int         step_sel;
      int         b;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      csr_write(bdlp_pkg::REG_DEBOUNCE, ($urandom() & ~32'hF) | {28'd0, deb});
      csr_write(bdlp_pkg::REG_LONG_PRESS, ($urandom() & ~32'hFFFF) | {16'd0, long_ms});
      csr_write(bdlp_pkg::REG_POLARITY, ($urandom() & ~32'h7) | {29'd0, pol});
      for (int i = 0; i < n; i++) begin
         for (b = 0; b < bdlp_pkg::NUM_BTN; b++)
            if ($urandom_range(cfg_debounce + 2) == 0) held_levels[b] = ~held_levels[b];
         lvl = held_levels;
         if ($urandom_range(19) == 0) lvl[$urandom_range(2)] ^= 1'b1;
         step_sel = $urandom_range(99);
         if (step_sel < 2) poll_time = $urandom();
         else if (step_sel < 12) poll_time = poll_time + $urandom_range(70000);
         else poll_time = poll_time + $urandom_range(300);
         send_poll(lvl, poll_time);
      end
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_first_poll();
      test_zero_samples();
      test_time_wrap();
      test_polarity();
      test_count_above_threshold();
      test_random_polls(44, 0, 0, 4'd0, 16'd0, 3'd0);
      test_random_polls(44, 0, 0, 4'd15, 16'hFFFF, 3'd7);
      test_random_polls(44, 50, 0, 4'($urandom_range(5)), 16'($urandom_range(1200)),
                        3'($urandom()));
      test_random_polls(44, 50, 0, 4'($urandom_range(5)), 16'($urandom_range(1200)),
                        3'($urandom()));
      test_random_polls(44, 0, 50, 4'($urandom_range(5)), 16'($urandom_range(1200)),
                        3'($urandom()));
      test_random_polls(44, 0, 50, 4'($urandom_range(15)), 16'($urandom()),
                        3'($urandom()));
      test_random_polls(44, 15, 15, 4'($urandom_range(5)), 16'($urandom_range(1200)),
                        3'($urandom()));
      test_random_polls(44, 15, 15, 4'($urandom_range(5)), 16'($urandom_range(1200)),
                        3'($urandom()));
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_events.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
